### rtl/pst_pkg.sv
package pst_pkg;

    // Table and reserve geometry.
    localparam int TABLE_ENTRIES = 64;
    localparam int RESERVE_SLOTS = 256;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W = $clog2(RESERVE_SLOTS);

    // The slot bitmap is searched one group of bits per cycle.
    localparam int GRP_BITS = 8;
    localparam int GPOS_W = $clog2(GRP_BITS);
    localparam int SLOT_GROUPS = (RESERVE_SLOTS + GRP_BITS - 1) / GRP_BITS;
    localparam int GRP_W = (SLOT_GROUPS > 1) ? $clog2(SLOT_GROUPS) : 1;
    localparam int PAD_BITS = SLOT_GROUPS * GRP_BITS;

    // Field widths.
    localparam int MODE_W = 2;
    localparam int PAGE_W = 20;
    localparam int STATUS_W = 2;
    localparam int START_W = 25;
    localparam int LBA_W = 28;
    localparam int SECTORS_PER_SLOT = 4096 / 512;
    localparam int SECT_SHIFT = $clog2(SECTORS_PER_SLOT);

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EVICT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPLACE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RESERVE_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd3;

    // What the commit step does to the state and the result.
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_NULL = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ERR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EVICT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BRING = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FRESH = 3'd5;

    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [START_W-1:0] start_t;
    typedef logic [LBA_W-1:0] lba_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [KIND_W-1:0] kind_t;

    // One table entry as held in the entry memory.
    typedef struct packed {
        page_t page;
        logic  evicted;
        slot_t slot;
    } entry_t;

    // Controller to datapath.
    typedef struct packed {
        logic    start;
        logic    scan;
        logic    slot_scan;
        logic    commit;
        kind_t   kind;
        status_t status;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        mode_t mode;
        logic  scan_done;
        logic  hit;
        logic  free_any;
        logic  slot_done;
        logic  slot_found;
        logic  out_free;
    } dp_sts_t;

endpackage

### rtl/pst_channels.sv
// Request channel: one operation per beat.
interface pst_req_if import pst_pkg::*; ();
    logic  valid;
    logic  ready;
    mode_t mode;
    page_t page_number;
    page_t frame_number;

    modport source (output valid, output mode, output page_number, output frame_number,
                    input ready);
    modport sink (input valid, input mode, input page_number, input frame_number,
                  output ready);
endinterface

// Response channel: one result per beat.
interface pst_rsp_if import pst_pkg::*; ();
    logic    valid;
    logic    ready;
    status_t status;
    logic    disk_write;
    logic    disk_read;
    lba_t    disk_lba;
    logic    map_request;
    page_t   map_frame;
    logic    fresh_entry;

    modport source (output valid, output status, output disk_write, output disk_read,
                    output disk_lba, output map_request, output map_frame,
                    output fresh_entry, input ready);
    modport sink (input valid, input status, input disk_write, input disk_read,
                  input disk_lba, input map_request, input map_frame,
                  input fresh_entry, output ready);
endinterface

// Configuration write channel for the reserve start block.
interface pst_cfg_if import pst_pkg::*; ();
    logic   valid;
    logic   ready;
    start_t reserve_start_block;

    modport source (output valid, output reserve_start_block, input ready);
    modport sink (input valid, input reserve_start_block, output ready);
endinterface

### rtl/page_swap_tracker_core.sv
// Page swap tracker. Keeps a table of TABLE_ENTRIES tracked pages, each resident or
// evicted to a swap slot, and a bitmap of RESERVE_SLOTS slots that reset clears.
// One operation is in flight at a time. The table lives in a single-port-read
// memory and is searched one entry per cycle up to the deciding entry (the first
// match or free entry; a miss scans all TABLE_ENTRIES). An evict then searches the
// bitmap for the lowest free slot, one 8-slot group per cycle. Mode 3 returns an
// all-zero result. The result waits in an output register; the next request is
// taken once the current one has been committed. The reserve start block is to be
// written by the user on the configuration channel while idle; the block itself
// does not enforce this. disk_lba is (slot + start) * 8 in 28 bits.
module page_swap_tracker_core import pst_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    pst_req_if.sink  req,
    pst_rsp_if.source rsp,
    pst_cfg_if.sink  cfg
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;
    logic      req_ready;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;

    pst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pst_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req_mode   (req.mode),
        .req_page   (req.page_number),
        .req_frame  (req.frame_number),
        .cfg_we     (cfg.valid),
        .cfg_start  (cfg.reserve_start_block),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .rsp_status (rsp.status),
        .rsp_write  (rsp.disk_write),
        .rsp_read   (rsp.disk_read),
        .rsp_lba    (rsp.disk_lba),
        .rsp_map    (rsp.map_request),
        .rsp_frame  (rsp.map_frame),
        .rsp_fresh  (rsp.fresh_entry)
    );

endmodule

### rtl/pst_ram.sv
module pst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/pst_ctrl.sv
module pst_ctrl import pst_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_SLOT = 2'd2;
    localparam logic [1:0] S_FIN = 2'd3;

    logic [1:0] state_reg, state_next;
    kind_t      kind_reg, kind_next;
    status_t    status_reg, status_next;

    assign req_ready = (state_reg == S_IDLE);

    // Sequencing: table search, optional slot search, then commit.
    always_comb
    begin
        state_next = state_reg;
        kind_next = kind_reg;
        status_next = status_reg;
        cmd = '0;
        cmd.kind = kind_reg;
        cmd.status = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.start = req_valid;
                if (req_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                unique case (sts.mode)
                    MODE_NONE:
                    begin
                        kind_next = KIND_NULL;
                        status_next = ST_OK;
                        state_next = S_FIN;
                    end
                    MODE_INSERT:
                    begin
                        if (sts.scan_done)
                        begin
                            kind_next = sts.hit ? KIND_INSERT : KIND_ERR;
                            status_next = sts.hit ? ST_OK : ST_TABLE_FULL;
                            state_next = S_FIN;
                        end
                    end
                    MODE_EVICT:
                    begin
                        if (sts.scan_done)
                        begin
                            if (sts.hit)
                            begin
                                state_next = S_SLOT;
                            end
                            else
                            begin
                                kind_next = KIND_ERR;
                                status_next = ST_NOT_FOUND;
                                state_next = S_FIN;
                            end
                        end
                    end
                    MODE_REPLACE:
                    begin
                        if (sts.scan_done)
                        begin
                            state_next = S_FIN;
                            status_next = ST_OK;
                            if (sts.hit)
                            begin
                                kind_next = KIND_BRING;
                            end
                            else if (sts.free_any)
                            begin
                                kind_next = KIND_FRESH;
                            end
                            else
                            begin
                                kind_next = KIND_ERR;
                                status_next = ST_TABLE_FULL;
                            end
                        end
                    end
                endcase
            end
            S_SLOT:
            begin
                cmd.slot_scan = 1'b1;
                if (sts.slot_done)
                begin
                    kind_next = sts.slot_found ? KIND_EVICT : KIND_ERR;
                    status_next = sts.slot_found ? ST_OK : ST_RESERVE_FULL;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // Commit only once the output register can take the result.
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg <= KIND_NULL;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg <= kind_next;
            status_reg <= status_next;
        end
    end

endmodule

### rtl/pst_dp.sv
module pst_dp import pst_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_cmd_t cmd,
    output dp_sts_t   sts,
    // Operation fields, sampled on the start command.
    input  mode_t     req_mode,
    input  page_t     req_page,
    input  page_t     req_frame,
    // Configuration write.
    input  logic      cfg_we,
    input  start_t    cfg_start,
    // Result register.
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output status_t   rsp_status,
    output logic      rsp_write,
    output logic      rsp_read,
    output lba_t      rsp_lba,
    output logic      rsp_map,
    output page_t     rsp_frame,
    output logic      rsp_fresh
);

    localparam logic [IDX_W:0] CNT_END = (IDX_W + 1)'(TABLE_ENTRIES);
    localparam idx_t IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [GRP_W-1:0] GRP_LAST = GRP_W'(SLOT_GROUPS - 1);

    // Operation and configuration registers.
    mode_t  mode_reg;
    page_t  page_reg;
    page_t  frame_reg;
    start_t start_reg;

    // Entry valid bits and the slot bitmap.
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [RESERVE_SLOTS-1:0] used_reg, used_next;
    logic [PAD_BITS-1:0]      pad_used;

    // Table search.
    logic [IDX_W:0] cnt_reg, cnt_next;
    logic           chk_vld_reg, chk_vld_next;
    idx_t           chk_idx_reg;
    idx_t           hit_idx_reg;
    slot_t          hit_slot_reg;
    logic           free_found_reg, free_found_next;
    idx_t           free_idx_reg;
    entry_t         rd_entry;
    logic           chk_live;
    logic           chk_entry_valid;
    logic           match_now;
    logic           hit_now;
    logic           free_now;

    // Slot search.
    logic [GRP_W-1:0]    gcnt_reg, gcnt_next;
    logic [GRP_BITS-1:0] grp_free;
    logic [GPOS_W-1:0]   grp_pos;
    logic [GRP_W+GPOS_W-1:0] slot_wide;
    slot_t               slot_reg;

    // Memory write side.
    logic   mem_we;
    idx_t   mem_waddr;
    entry_t mem_wdata;

    // Result.
    logic    out_valid_reg, out_valid_next;
    status_t res_status;
    logic    res_write;
    logic    res_read;
    lba_t    res_lba;
    logic    res_map;
    page_t   res_frame;
    logic    res_fresh;
    slot_t   lba_slot;
    start_t  lba_sum;
    status_t rsp_status_reg;
    logic    rsp_write_reg;
    logic    rsp_read_reg;
    lba_t    rsp_lba_reg;
    logic    rsp_map_reg;
    page_t   rsp_frame_reg;
    logic    rsp_fresh_reg;

    pst_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_entries (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    // Compare stage: the entry read in the previous cycle against the key.
    assign chk_live = chk_vld_reg && cmd.scan;
    assign chk_entry_valid = valid_reg[chk_idx_reg];
    assign match_now = chk_entry_valid && (rd_entry.page == page_reg)
                       && (rd_entry.evicted == (mode_reg == MODE_REPLACE));
    assign free_now = chk_live && !chk_entry_valid;
    assign hit_now = chk_live && ((mode_reg == MODE_INSERT) ? !chk_entry_valid : match_now);

    // Search counters and the lowest free entry.
    always_comb
    begin
        cnt_next = cnt_reg;
        chk_vld_next = 1'b0;
        free_found_next = free_found_reg;
        if (cmd.start)
        begin
            cnt_next = '0;
            free_found_next = 1'b0;
        end
        else if (cmd.scan)
        begin
            chk_vld_next = (cnt_reg < CNT_END);
            if (cnt_reg < CNT_END)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            if (free_now)
            begin
                free_found_next = 1'b1;
            end
        end
    end

    // Bitmap padded with taken bits up to a whole number of groups.
    for (genvar gi = 0; gi < PAD_BITS; gi++)
    begin : g_pad
        if (gi < RESERVE_SLOTS)
        begin : g_real
            assign pad_used[gi] = used_reg[gi];
        end
        else
        begin : g_fill
            assign pad_used[gi] = 1'b1;
        end
    end

    // Lowest free bit of the current group.
    always_comb
    begin
        grp_free = ~pad_used[gcnt_reg * GRP_BITS +: GRP_BITS];
        grp_pos = '0;
        for (int b = GRP_BITS - 1; b >= 0; b--)
        begin
            if (grp_free[b])
            begin
                grp_pos = GPOS_W'(b);
            end
        end
    end

    assign slot_wide = {gcnt_reg, grp_pos};

    always_comb
    begin
        gcnt_next = gcnt_reg;
        if (cmd.start)
        begin
            gcnt_next = '0;
        end
        else if (cmd.slot_scan && (grp_free == '0) && (gcnt_reg != GRP_LAST))
        begin
            gcnt_next = gcnt_reg + 1'b1;
        end
    end

    // Slot address for the result.
    assign lba_slot = (cmd.kind == KIND_BRING) ? hit_slot_reg : slot_reg;
    assign lba_sum = START_W'(lba_slot) + start_reg;

    // Commit: entry write, valid and bitmap update, result fields.
    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = hit_idx_reg;
        mem_wdata = '{page: page_reg, evicted: 1'b0, slot: '0};
        valid_next = valid_reg;
        used_next = used_reg;
        res_status = ST_OK;
        res_write = 1'b0;
        res_read = 1'b0;
        res_lba = '0;
        res_map = 1'b0;
        res_frame = '0;
        res_fresh = 1'b0;
        unique case (cmd.kind)
            KIND_NULL:
            begin
            end
            KIND_ERR:
            begin
                res_status = cmd.status;
            end
            KIND_INSERT:
            begin
                mem_we = cmd.commit;
                if (cmd.commit)
                begin
                    valid_next[hit_idx_reg] = 1'b1;
                end
            end
            KIND_EVICT:
            begin
                mem_we = cmd.commit;
                mem_wdata = '{page: page_reg, evicted: 1'b1, slot: slot_reg};
                if (cmd.commit)
                begin
                    used_next[slot_reg] = 1'b1;
                end
                res_write = 1'b1;
                res_lba = LBA_W'({lba_sum, SECT_SHIFT'(0)});
            end
            KIND_BRING:
            begin
                mem_we = cmd.commit;
                mem_wdata = '{page: page_reg, evicted: 1'b0, slot: hit_slot_reg};
                if (cmd.commit)
                begin
                    used_next[hit_slot_reg] = 1'b0;
                end
                res_read = 1'b1;
                res_lba = LBA_W'({lba_sum, SECT_SHIFT'(0)});
                res_map = 1'b1;
                res_frame = frame_reg;
            end
            KIND_FRESH:
            begin
                mem_we = cmd.commit;
                mem_waddr = free_idx_reg;
                if (cmd.commit)
                begin
                    valid_next[free_idx_reg] = 1'b1;
                end
                res_map = 1'b1;
                res_frame = frame_reg;
                res_fresh = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            valid_reg <= '0;
            used_reg <= '0;
            cnt_reg <= '0;
            chk_vld_reg <= 1'b0;
            free_found_reg <= 1'b0;
            gcnt_reg <= '0;
            out_valid_reg <= 1'b0;
            mode_reg <= MODE_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                start_reg <= cfg_start;
            end
            if (cmd.start)
            begin
                mode_reg <= req_mode;
            end
            valid_reg <= valid_next;
            used_reg <= used_next;
            cnt_reg <= cnt_next;
            chk_vld_reg <= chk_vld_next;
            free_found_reg <= free_found_next;
            gcnt_reg <= gcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            page_reg <= req_page;
            frame_reg <= req_frame;
        end
        chk_idx_reg <= cnt_reg[IDX_W-1:0];
        if (hit_now)
        begin
            hit_idx_reg <= chk_idx_reg;
            hit_slot_reg <= rd_entry.slot;
        end
        if (free_now && !free_found_reg)
        begin
            free_idx_reg <= chk_idx_reg;
        end
        if (cmd.slot_scan && (grp_free != '0))
        begin
            slot_reg <= SLOT_W'(slot_wide);
        end
        if (cmd.commit)
        begin
            rsp_status_reg <= res_status;
            rsp_write_reg <= res_write;
            rsp_read_reg <= res_read;
            rsp_lba_reg <= res_lba;
            rsp_map_reg <= res_map;
            rsp_frame_reg <= res_frame;
            rsp_fresh_reg <= res_fresh;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_status = rsp_status_reg;
    assign rsp_write = rsp_write_reg;
    assign rsp_read = rsp_read_reg;
    assign rsp_lba = rsp_lba_reg;
    assign rsp_map = rsp_map_reg;
    assign rsp_frame = rsp_frame_reg;
    assign rsp_fresh = rsp_fresh_reg;

    // Status toward the controller.
    always_comb
    begin
        sts.mode = mode_reg;
        sts.hit = hit_now;
        sts.scan_done = hit_now || (chk_live && (chk_idx_reg == IDX_LAST));
        sts.free_any = free_found_reg || free_now;
        sts.slot_done = cmd.slot_scan && ((grp_free != '0) || (gcnt_reg == GRP_LAST));
        sts.slot_found = (grp_free != '0);
        sts.out_free = !out_valid_reg || rsp_ready;
    end

endmodule

### rtl/pst_checker.sv
module pst_checker import pst_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    req_valid,
    input logic    req_ready,
    input logic    rsp_valid,
    input logic    rsp_ready,
    input status_t status,
    input logic    disk_write,
    input logic    disk_read,
    input lba_t    disk_lba,
    input logic    map_request,
    input page_t   map_frame,
    input logic    fresh_entry
);

    // A stalled result beat holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(disk_lba)
            && $stable(map_frame) && $stable(disk_write) && $stable(disk_read))
        else $error("result beat changed while stalled");

    // Only one operation is in flight: no request is taken right after one.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an operation was in flight");

    // An error result carries nothing but its status.
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_OK) |-> !disk_write && !disk_read && (disk_lba == '0)
            && !map_request && (map_frame == '0) && !fresh_entry)
        else $error("error result with side effects");

    // Disk and map requests are consistent with each other.
    a_disk_map: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(disk_write && disk_read) && !(disk_write && map_request)
            && (disk_read == (map_request && !fresh_entry))
            && ((disk_write || disk_read) || (disk_lba == '0))
            && (map_request || (map_frame == '0)))
        else $error("inconsistent disk and map requests");

    // Slot addresses are aligned to whole slots.
    a_lba_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (disk_lba[SECT_SHIFT-1:0] == '0))
        else $error("disk address not slot aligned");

endmodule

bind page_swap_tracker_core pst_checker u_pst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .disk_write  (rsp.disk_write),
    .disk_read   (rsp.disk_read),
    .disk_lba    (rsp.disk_lba),
    .map_request (rsp.map_request),
    .map_frame   (rsp.map_frame),
    .fresh_entry (rsp.fresh_entry)
);

### tb/testbench.sv
module testbench;
    import pst_pkg::*;

    // One result beat, in the field order of the response channel.
    typedef struct packed {
        status_t status;
        logic    disk_write;
        logic    disk_read;
        lba_t    disk_lba;
        logic    map_request;
        page_t   map_frame;
        logic    fresh_entry;
    } swap_rsp_t;

    typedef enum logic {ROW_OP, ROW_CFG} row_kind_t;

    // One row of the directed stimulus: an operation or a start block write.
    typedef struct packed {
        row_kind_t kind;
        mode_t     mode;
        page_t     page;
        page_t     frame;
        start_t    start;
        logic      typed;
        swap_rsp_t exp;
    } stim_row_t;

    localparam int N_DIRECTED = 19;
    localparam int N_PHASE_OPS = 375;
    localparam int POOL_SIZE = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 200;
    localparam int SHOWN_ERRORS = 10;

    localparam swap_rsp_t ALL_ZERO = '0;

    // Rows marked typed carry their result; the others are predicted.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_OP, MODE_NONE, 20'hFFFFF, 20'hFFFFF, '0, 1'b1, ALL_ZERO},
        '{ROW_OP, MODE_EVICT, 20'h00000, 20'hFFFFF, '0, 1'b1,
          '{ST_NOT_FOUND, 1'b0, 1'b0, 28'd0, 1'b0, 20'h0, 1'b0}},
        '{ROW_OP, MODE_REPLACE, 20'hFFFFF, 20'hFFFFF, '0, 1'b1,
          '{ST_OK, 1'b0, 1'b0, 28'd0, 1'b1, 20'hFFFFF, 1'b1}},
        '{ROW_OP, MODE_INSERT, 20'h00000, 20'hFFFFF, '0, 1'b1, ALL_ZERO},
        '{ROW_OP, MODE_EVICT, 20'h00000, 20'h00000, '0, 1'b1,
          '{ST_OK, 1'b1, 1'b0, 28'd0, 1'b0, 20'h0, 1'b0}},
        '{ROW_OP, MODE_EVICT, 20'hFFFFF, 20'h00000, '0, 1'b1,
          '{ST_OK, 1'b1, 1'b0, 28'd8, 1'b0, 20'h0, 1'b0}},
        '{ROW_OP, MODE_EVICT, 20'h00000, 20'h00000, '0, 1'b1,
          '{ST_NOT_FOUND, 1'b0, 1'b0, 28'd0, 1'b0, 20'h0, 1'b0}},
        '{ROW_OP, MODE_REPLACE, 20'h00000, 20'h00000, '0, 1'b1,
          '{ST_OK, 1'b0, 1'b1, 28'd0, 1'b1, 20'h0, 1'b0}},
        '{ROW_OP, MODE_INSERT, 20'h00000, 20'h12345, '0, 1'b1, ALL_ZERO},
        '{ROW_OP, MODE_EVICT, 20'h00000, 20'h00000, '0, 1'b0, ALL_ZERO},
        '{ROW_OP, MODE_REPLACE, 20'hFFFFF, 20'h5A5A5, '0, 1'b0, ALL_ZERO},
        '{ROW_OP, MODE_NONE, 20'h00000, 20'h00000, '0, 1'b1, ALL_ZERO},
        '{ROW_CFG, MODE_NONE, 20'h0, 20'h0, 25'h1FFFFFF, 1'b0, ALL_ZERO},
        '{ROW_OP, MODE_EVICT, 20'h00000, 20'h00000, '0, 1'b0, ALL_ZERO},
        '{ROW_OP, MODE_EVICT, 20'hFFFFF, 20'h00000, '0, 1'b0, ALL_ZERO},
        '{ROW_OP, MODE_REPLACE, 20'h00000, 20'hAAAAA, '0, 1'b0, ALL_ZERO},
        '{ROW_OP, MODE_REPLACE, 20'hFFFFF, 20'h55555, '0, 1'b0, ALL_ZERO},
        '{ROW_OP, MODE_REPLACE, 20'h12345, 20'h0F0F0, '0, 1'b0, ALL_ZERO},
        '{ROW_OP, MODE_INSERT, 20'hFFFFF, 20'h00000, '0, 1'b0, ALL_ZERO}
    };

    logic clk;
    logic rst_n;

    pst_req_if req_ch ();
    pst_rsp_if rsp_ch ();
    pst_cfg_if cfg_ch ();

    page_swap_tracker_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the page table, the slot bitmap and the start block.
    logic      ent_valid [TABLE_ENTRIES];
    page_t     ent_page [TABLE_ENTRIES];
    logic      ent_evicted [TABLE_ENTRIES];
    slot_t     ent_slot [TABLE_ENTRIES];
    logic      slot_taken [RESERVE_SLOTS];
    start_t    reserve_start;

    swap_rsp_t pending_results [$];
    page_t     page_pool [POOL_SIZE];
    int        error_count;
    int        send_idle_pct;
    int        stall_pct;
    int        hold_asks;

    // Lowest valid entry for the page in the given residency, or -1.
    function automatic int find_entry(page_t pg, logic evicted);
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            if (ent_valid[k] && ent_page[k] == pg && ent_evicted[k] == evicted)
                return k;
        end
        return -1;
    endfunction

    function automatic int find_free_entry();
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            if (!ent_valid[k])
                return k;
        end
        return -1;
    endfunction

    // Sector address of a slot; wraps to the 28-bit address width.
    function automatic lba_t slot_lba(slot_t sl);
        logic [31:0] block;
        block = 32'(sl) + 32'(reserve_start);
        return lba_t'(block * SECTORS_PER_SLOT);
    endfunction

    // Applies one operation to the shadow state and returns its result.
    function automatic swap_rsp_t track_op(mode_t m, page_t pg, page_t fr);
        swap_rsp_t r;
        int        e;
        int        s;
        r = '0;
        case (m)
            MODE_INSERT:
            begin
                e = find_free_entry();
                if (e < 0)
                begin
                    r.status = ST_TABLE_FULL;
                end
                else
                begin
                    ent_valid[e] = 1'b1;
                    ent_page[e] = pg;
                    ent_evicted[e] = 1'b0;
                    ent_slot[e] = '0;
                end
            end
            MODE_EVICT:
            begin
                e = find_entry(pg, 1'b0);
                if (e < 0)
                begin
                    r.status = ST_NOT_FOUND;
                end
                else
                begin
                    s = -1;
                    for (int k = RESERVE_SLOTS - 1; k >= 0; k--)
                    begin
                        if (!slot_taken[k])
                            s = k;
                    end
                    if (s < 0)
                    begin
                        r.status = ST_RESERVE_FULL;
                    end
                    else
                    begin
                        slot_taken[s] = 1'b1;
                        ent_evicted[e] = 1'b1;
                        ent_slot[e] = slot_t'(s);
                        r.disk_write = 1'b1;
                        r.disk_lba = slot_lba(slot_t'(s));
                    end
                end
            end
            MODE_REPLACE:
            begin
                e = find_entry(pg, 1'b1);
                if (e >= 0)
                begin
                    slot_taken[ent_slot[e]] = 1'b0;
                    ent_evicted[e] = 1'b0;
                    r.disk_read = 1'b1;
                    r.disk_lba = slot_lba(ent_slot[e]);
                    r.map_request = 1'b1;
                    r.map_frame = fr;
                end
                else
                begin
                    e = find_free_entry();
                    if (e < 0)
                    begin
                        r.status = ST_TABLE_FULL;
                    end
                    else
                    begin
                        ent_valid[e] = 1'b1;
                        ent_page[e] = pg;
                        ent_evicted[e] = 1'b0;
                        ent_slot[e] = '0;
                        r.fresh_entry = 1'b1;
                        r.map_request = 1'b1;
                        r.map_frame = fr;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Offers one request beat after an optional gap and records its result.
    task automatic send_op(mode_t m, page_t pg, page_t fr, logic typed, swap_rsp_t typed_exp);
        swap_rsp_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode <= m;
        req_ch.page_number <= pg;
        req_ch.frame_number <= fr;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = track_op(m, pg, fr);
        pending_results.push_back(typed ? typed_exp : predicted);
    endtask

    // Mostly pages from a small pool so that entries get hit again.
    task automatic send_random_op();
        int    pick;
        mode_t m;
        page_t pg;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            m = MODE_INSERT;
        else if (pick < 55)
            m = MODE_EVICT;
        else if (pick < 95)
            m = MODE_REPLACE;
        else
            m = MODE_NONE;
        if ($urandom_range(0, 9) == 0)
            pg = page_t'($urandom);
        else
            pg = page_pool[$urandom_range(0, POOL_SIZE - 1)];
        send_op(m, pg, page_t'($urandom), 1'b0, ALL_ZERO);
    endtask

    // Stops offering requests and waits until every result is back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Writes the start block once the block is idle.
    task automatic write_start(start_t value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.reserve_start_block <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        reserve_start = value;
        cfg_ch.valid <= 1'b0;
    endtask

    // Compares one accepted result beat with the oldest expectation.
    task automatic check_beat(swap_rsp_t got);
        swap_rsp_t exp;
        if (pending_results.size() == 0)
        begin
            error_count++;
            if (error_count <= SHOWN_ERRORS)
                $display("unexpected result beat: status=%0d wr=%0b rd=%0b lba=%h",
                         got.status, got.disk_write, got.disk_read, got.disk_lba);
            return;
        end
        exp = pending_results.pop_front();
        if (got.status !== exp.status || got.disk_write !== exp.disk_write ||
            got.disk_read !== exp.disk_read || got.disk_lba !== exp.disk_lba ||
            got.map_request !== exp.map_request || got.map_frame !== exp.map_frame ||
            got.fresh_entry !== exp.fresh_entry)
        begin
            error_count++;
            if (error_count <= SHOWN_ERRORS)
            begin
                $display("mismatch expected: st=%0d wr=%0b rd=%0b lba=%h map=%0b fr=%h fresh=%0b",
                         exp.status, exp.disk_write, exp.disk_read, exp.disk_lba,
                         exp.map_request, exp.map_frame, exp.fresh_entry);
                $display("         actual:   st=%0d wr=%0b rd=%0b lba=%h map=%0b fr=%h fresh=%0b",
                         got.status, got.disk_write, got.disk_read, got.disk_lba,
                         got.map_request, got.map_frame, got.fresh_entry);
            end
        end
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Shadow state after reset.
    initial
    begin
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            ent_valid[k] = 1'b0;
            ent_page[k] = '0;
            ent_evicted[k] = 1'b0;
            ent_slot[k] = '0;
        end
        for (int k = 0; k < RESERVE_SLOTS; k++)
            slot_taken[k] = 1'b0;
        reserve_start = '0;
        error_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_asks = 0;
    end

    // Receiver: checks result beats and stalls as the phase asks, with long holds on request.
    initial
    begin
        int holds_done;
        int hold_left;
        swap_rsp_t got;
        holds_done = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got.status = rsp_ch.status;
                got.disk_write = rsp_ch.disk_write;
                got.disk_read = rsp_ch.disk_read;
                got.disk_lba = rsp_ch.disk_lba;
                got.map_request = rsp_ch.map_request;
                got.map_frame = rsp_ch.map_frame;
                got.fresh_entry = rsp_ch.fresh_entry;
                check_beat(got);
            end
            if (hold_asks != holds_done)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Watchdog on cycles without any beat on any channel.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Sender: reset, directed rows, then random phases with varied idling.
    initial
    begin
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.mode <= MODE_INSERT;
        req_ch.page_number <= '0;
        req_ch.frame_number <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.reserve_start_block <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_start(directed_rows[i].start);
            else
                send_op(directed_rows[i].mode, directed_rows[i].page, directed_rows[i].frame,
                        directed_rows[i].typed, directed_rows[i].exp);
        end

        for (int k = 0; k < POOL_SIZE; k++)
            page_pool[k] = page_t'($urandom);

        for (int ph = 0; ph < 4; ph++)
        begin
            // Start block per phase: random, largest, zero, random.
            case (ph)
                0: write_start(start_t'($urandom));
                1: write_start('1);
                2: write_start('0);
                default: write_start(start_t'($urandom));
            endcase
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 61;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 61;
                end
                default:
                begin
                    send_idle_pct = 8;
                    stall_pct = 8;
                end
            endcase
            for (int i = 0; i < N_PHASE_OPS; i++)
            begin
                // A long receiver hold while requests keep coming.
                if (i == 150 && (ph == 0 || ph == 2))
                    hold_asks++;
                // A pause on the request side until the block has drained.
                if (i == 250)
                    wait_drained();
                send_random_op();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
